// ----- hw/rtl/central_difference_gradient_magnitude_core_assert.svh -----
// assertion macros shared by the gradient magnitude rtl
// each macro takes a label, clock, synchronous reset, a condition and a check
`ifndef CENTRAL_DIFFERENCE_GRADIENT_MAGNITUDE_CORE_ASSERT_SVH
`define CENTRAL_DIFFERENCE_GRADIENT_MAGNITUDE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check holds in the same cycle as the condition
`define CDGM_ASSERT_IMPLY(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("cdgm same-cycle check failed");
// check holds in the cycle after the condition
`define CDGM_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("cdgm next-cycle check failed");
`else
`define CDGM_ASSERT_IMPLY(name, clk, rst, cond, expr)
`define CDGM_ASSERT_NEXT(name, clk, rst, cond, expr)
`endif

`endif

// ----- hw/rtl/cdgm_pkg.sv -----
package cdgm_pkg;

   // sizes
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int PIXEL_BITS        = 8;
   localparam int ROOT_BITS         = 9;
   localparam int WIDTH_BITS        = 11;
   localparam int HEIGHT_BITS       = 13;
   localparam int THRESH_BITS       = 8;
   localparam int CSR_ADDR_BITS     = 4;
   localparam int CSR_DATA_BITS     = 32;

   // register reset values
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 8'd0;

   // largest possible output magnitude
   localparam logic [PIXEL_BITS-1:0] MAG_MAX = 8'd180;

   // input word kinds
   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH         = 2'd0,
      REG_IMAGE_HEIGHT        = 2'd1,
      REG_MAGNITUDE_THRESHOLD = 2'd2
   } cdgm_reg_index_type;

endpackage

// ----- hw/rtl/cdgm_line_store.sv -----
module cdgm_line_store #(
   parameter int MAX_WIDTH = cdgm_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                swapped,
   input  logic [$clog2(MAX_WIDTH)-1:0]        newer_addr_a,
   input  logic [$clog2(MAX_WIDTH)-1:0]        newer_addr_b,
   input  logic [$clog2(MAX_WIDTH)-1:0]        older_addr,
   input  logic                                write_en,
   input  logic [cdgm_pkg::PIXEL_BITS-1:0]     write_data,
   output logic [cdgm_pkg::PIXEL_BITS-1:0]     newer_data_a,
   output logic [cdgm_pkg::PIXEL_BITS-1:0]     newer_data_b,
   output logic [cdgm_pkg::PIXEL_BITS-1:0]     older_data
);
   import cdgm_pkg::*;

   // two row banks, roles swap at every row end
   logic [PIXEL_BITS-1:0] older_row_store [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] newer_row_store [MAX_WIDTH];

   logic [PIXEL_BITS-1:0] older_a_ff;
   logic [PIXEL_BITS-1:0] older_b_ff;
   logic [PIXEL_BITS-1:0] newer_a_ff;
   logic [PIXEL_BITS-1:0] newer_b_ff;
   logic                  swapped_ff;

   // bank 0: the older row while not swapped
   always_ff @(posedge clock) begin
      if (write_en && !swapped) begin
         older_row_store[older_addr] <= write_data;
      end
      older_a_ff <= older_row_store[swapped ? newer_addr_a : older_addr];
      older_b_ff <= older_row_store[newer_addr_b];
   end

   // bank 1: the newer row while not swapped
   always_ff @(posedge clock) begin
      if (write_en && swapped) begin
         newer_row_store[older_addr] <= write_data;
      end
      newer_a_ff <= newer_row_store[swapped ? older_addr : newer_addr_a];
      newer_b_ff <= newer_row_store[newer_addr_b];
   end

   // role of each bank at read time
   always_ff @(posedge clock) begin
      if (reset) begin
         swapped_ff <= 1'b0;
      end else begin
         swapped_ff <= swapped;
      end
   end

   assign newer_data_a = swapped_ff ? older_a_ff : newer_a_ff;
   assign newer_data_b = swapped_ff ? older_b_ff : newer_b_ff;
   assign older_data   = swapped_ff ? newer_a_ff : older_a_ff;

endmodule

// ----- hw/rtl/cdgm_root_unit.sv -----
`include "central_difference_gradient_magnitude_core_assert.svh"

module cdgm_root_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [cdgm_pkg::PIXEL_BITS-1:0]  dx_abs,
   input  logic [cdgm_pkg::PIXEL_BITS-1:0]  dy_abs,
   output logic                             done,
   output logic [cdgm_pkg::ROOT_BITS-1:0]   root
);
   import cdgm_pkg::*;

   localparam int SQ_BITS  = 2 * PIXEL_BITS;
   localparam int RAD_BITS = SQ_BITS + 1;

   typedef enum logic [1:0] {
      U_IDLE,
      U_SQUARE,
      U_SUM,
      U_ITER
   } unit_state_type;

   unit_state_type state_ff, state_in;
   logic done_ff, done_in;

   logic [PIXEL_BITS-1:0] ax_ff, ax_in;
   logic [PIXEL_BITS-1:0] ay_ff, ay_in;
   logic [SQ_BITS-1:0]    sqx_ff, sqx_in;
   logic [SQ_BITS-1:0]    sqy_ff, sqy_in;
   logic [RAD_BITS-1:0]   rem_ff, rem_in;
   logic [RAD_BITS-1:0]   res_ff, res_in;
   logic [RAD_BITS-1:0]   bit_ff, bit_in;

   logic [RAD_BITS:0]     trial;
   logic                  fits;

   // one result bit per iteration
   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign fits  = {1'b0, rem_ff} >= trial;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               ax_in    = dx_abs;
               ay_in    = dy_abs;
               state_in = U_SQUARE;
            end
         end
         U_SQUARE: begin
            sqx_in   = ax_ff * ax_ff;
            sqy_in   = ay_ff * ay_ff;
            state_in = U_SUM;
         end
         U_SUM: begin
            rem_in   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
            res_in   = '0;
            bit_in   = RAD_BITS'(1) << (RAD_BITS - 1);
            state_in = U_ITER;
         end
         U_ITER: begin
            if (fits) begin
               rem_in = rem_ff - trial[RAD_BITS-1:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   // state and done flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_BITS-1:0];

   `CDGM_ASSERT_IMPLY(a_start_when_idle, clock, reset, start, state_ff == U_IDLE)
   `CDGM_ASSERT_IMPLY(a_bit_onehot, clock, reset, state_ff == U_ITER, $onehot(bit_ff))
   `CDGM_ASSERT_NEXT(a_done_single, clock, reset, done_ff, !done_ff)

endmodule

// ----- hw/rtl/central_difference_gradient_magnitude_core.sv -----
// central difference gradient magnitude core
// req_ carries one greyscale pixel per word in raster order (tuser low), or a drain
// tick (tuser high); after each frame the host sends image_width drain ticks.
// rsp_ gives floor(sqrt(dx*dx + dy*dy) / 2) per pixel, zeroed below the threshold,
// one row behind the input; tuser marks the frame's last pixel, tlast is always set.
// the csr_ port holds image_width, image_height and magnitude_threshold at 0x0,
// 0x4 and 0x8; change them only between frames.
// an item that yields a result is accepted in S_IDLE, reads the line stores in
// S_RD1 and S_RD2, runs the 9-step square-root unit in S_ROOT and leaves its
// result in S_OUT; no new word is accepted until the core is back in S_IDLE.
// the first row gives no result and returns from S_RD2 to S_IDLE; pixels or drain
// ticks outside their phase give no result and leave the core in S_IDLE.
// a finished result sits in the output register while the next word is taken;
// a stalled receiver holds the core in its output state once a second result is
// ready. reset clears the counters, bank select and registers to their defaults;
// the line stores are not cleared and need no sweep.
`include "central_difference_gradient_magnitude_core_assert.svh"

module central_difference_gradient_magnitude_core #(
   parameter int MAX_WIDTH = cdgm_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] pixel_value
   input  logic                                 req_tuser,   // [0] action
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [7:0] gradient_value
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser,   // [0] frame_end
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cdgm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [cdgm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [cdgm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import cdgm_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = (AW + 1 > WIDTH_BITS) ? AW + 1 : WIDTH_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD1,
      S_RD2,
      S_ROOT,
      S_OUT
   } core_state_type;

   function automatic logic [PIXEL_BITS-1:0] abs_diff(input logic [PIXEL_BITS-1:0] a,
                                                      input logic [PIXEL_BITS-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // control registers
   core_state_type             state_ff, state_in;
   logic [AW-1:0]              col_ff, col_in;
   logic [HEIGHT_BITS-1:0]     row_ff, row_in;
   logic                       swapped_ff, swapped_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [WIDTH_BITS-1:0]      width_ff, width_in;
   logic [HEIGHT_BITS-1:0]     height_ff, height_in;
   logic [THRESH_BITS-1:0]     thresh_ff, thresh_in;

   // payload registers
   logic                       act_ff;
   logic [PIXEL_BITS-1:0]      pix_ff;
   logic [PIXEL_BITS-1:0]      win_left_ff;
   logic [PIXEL_BITS-1:0]      win_right_ff;
   logic [PIXEL_BITS-1:0]      older_row_ff;
   logic                       frame_end_ff;
   logic [PIXEL_BITS-1:0]      rsp_data_ff;
   logic                       rsp_user_ff;

   logic [CW-1:0]              w_ext;
   logic [CW-1:0]              w_eff;
   logic [CW-1:0]              c_next;
   logic                       wrap;
   logic [AW-1:0]              col_inc;
   logic [AW-1:0]              left_addr;
   logic [AW-1:0]              right_addr;
   logic [HEIGHT_BITS-1:0]     h_eff;
   logic                       row_done;
   logic                       item_ignored;
   logic                       accept;
   logic                       out_free;

   logic [AW-1:0]              newer_addr_a;
   logic [PIXEL_BITS-1:0]      newer_data_a;
   logic [PIXEL_BITS-1:0]      newer_data_b;
   logic [PIXEL_BITS-1:0]      older_data;
   logic                       write_en;

   logic                       use_older;
   logic                       produce;
   logic [PIXEL_BITS-1:0]      up_pix;
   logic [PIXEL_BITS-1:0]      down_pix;
   logic [PIXEL_BITS-1:0]      dx_abs;
   logic [PIXEL_BITS-1:0]      dy_abs;
   logic                       root_start;
   logic                       root_done;
   logic [ROOT_BITS-1:0]       root;
   logic [PIXEL_BITS-1:0]      mag;
   logic [PIXEL_BITS-1:0]      gradient;

   logic                       cfg_write;
   logic [1:0]                 cfg_index;

   // effective frame geometry
   assign w_ext    = CW'(width_ff);
   assign w_eff    = (w_ext == '0) ? CW'(1) :
                     ((w_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_ext);
   assign h_eff    = (height_ff == '0) ? HEIGHT_BITS'(1) : height_ff;
   assign row_done = row_ff >= h_eff;

   // column neighbors with edge replication
   assign c_next     = CW'(col_ff) + CW'(1);
   assign wrap       = c_next >= w_eff;
   assign col_inc    = AW'(col_ff + AW'(1));
   assign left_addr  = (col_ff == '0) ? '0 : AW'(col_ff - AW'(1));
   assign right_addr = wrap ? col_ff : col_inc;

   // input handshake
   assign req_tready   = state_ff == S_IDLE;
   assign accept       = req_tvalid && req_tready;
   assign item_ignored = (req_tuser == ACTION_PIXEL && row_done) ||
                         (req_tuser == ACTION_DRAIN && !row_done);

   // line store ports: left and right on accept, center in the cycle after
   assign newer_addr_a = (state_ff == S_RD1) ? col_ff : left_addr;
   assign write_en     = (state_ff == S_RD2) && (act_ff == ACTION_PIXEL);

   cdgm_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock        (clock),
      .reset        (reset),
      .swapped      (swapped_ff),
      .newer_addr_a (newer_addr_a),
      .newer_addr_b (right_addr),
      .older_addr   (col_ff),
      .write_en     (write_en),
      .write_data   (pix_ff),
      .newer_data_a (newer_data_a),
      .newer_data_b (newer_data_b),
      .older_data   (older_data)
   );

   // vertical neighbors, top and bottom rows replicate the center row
   assign use_older = (act_ff == ACTION_PIXEL) ? (row_ff >= HEIGHT_BITS'(2)) :
                                                 (height_ff >= HEIGHT_BITS'(2));
   assign up_pix    = use_older ? older_row_ff : newer_data_a;
   assign down_pix  = (act_ff == ACTION_PIXEL) ? pix_ff : newer_data_a;
   assign produce   = (act_ff == ACTION_DRAIN) || (row_ff != '0);
   assign dx_abs    = abs_diff(win_right_ff, win_left_ff);
   assign dy_abs    = abs_diff(down_pix, up_pix);
   assign root_start = (state_ff == S_RD2) && produce;

   cdgm_root_unit u_root_unit (
      .clock  (clock),
      .reset  (reset),
      .start  (root_start),
      .dx_abs (dx_abs),
      .dy_abs (dy_abs),
      .done   (root_done),
      .root   (root)
   );

   // halve and threshold
   assign mag      = root[ROOT_BITS-1:1];
   assign gradient = (mag < thresh_ff) ? '0 : mag;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // csr write decode
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_index = csr_paddr[3:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            REG_IMAGE_WIDTH:         width_in  = csr_pwdata[WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT:        height_in = csr_pwdata[HEIGHT_BITS-1:0];
            REG_MAGNITUDE_THRESHOLD: thresh_in = csr_pwdata[THRESH_BITS-1:0];
            default:                 width_in  = width_ff;
         endcase
      end
   end

   // csr read mux
   always_comb begin
      unique case (cfg_index)
         REG_IMAGE_WIDTH:         csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT:        csr_prdata = CSR_DATA_BITS'(height_ff);
         REG_MAGNITUDE_THRESHOLD: csr_prdata = CSR_DATA_BITS'(thresh_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      swapped_in   = swapped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && !item_ignored) begin
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            state_in = S_RD2;
         end
         S_RD2: begin
            if (wrap) begin
               col_in = '0;
               if (act_ff == ACTION_PIXEL) begin
                  row_in     = HEIGHT_BITS'(row_ff + HEIGHT_BITS'(1));
                  swapped_in = !swapped_ff;
               end else begin
                  row_in = '0;
               end
            end else begin
               col_in = col_inc;
            end
            state_in = produce ? S_ROOT : S_IDLE;
         end
         S_ROOT: begin
            if (root_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, counters and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         swapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         thresh_ff    <= THRESH_RESET;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         swapped_ff   <= swapped_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         thresh_ff    <= thresh_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_tuser;
         pix_ff <= req_tdata;
      end
      if (state_ff == S_RD1) begin
         win_left_ff  <= newer_data_a;
         win_right_ff <= newer_data_b;
         older_row_ff <= older_data;
      end
      if (state_ff == S_RD2) begin
         frame_end_ff <= (act_ff == ACTION_DRAIN) && wrap;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff <= gradient;
         rsp_user_ff <= frame_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = 1'b1;

   `CDGM_ASSERT_IMPLY(a_col_in_range, clock, reset, 1'b1, CW'(col_ff) < CW'(MAX_WIDTH))
   `CDGM_ASSERT_IMPLY(a_done_when_waiting, clock, reset, root_done, state_ff == S_ROOT)
   `CDGM_ASSERT_IMPLY(a_result_in_range, clock, reset, rsp_valid_ff, rsp_data_ff <= MAG_MAX)
   `CDGM_ASSERT_NEXT(a_frame_end_rewinds, clock, reset, state_ff == S_RD2 && act_ff == ACTION_DRAIN && wrap, row_ff == '0 && col_ff == '0)

endmodule

// ----- bench/gradient_stream_checker.sv -----
module gradient_stream_checker
   import cdgm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] pixel_value
   input  logic                     req_tuser,   // [0] action
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [7:0]               rsp_tdata,   // [7:0] gradient_value
   input  logic                     rsp_tlast,
   input  logic                     rsp_tuser,   // [0] frame_end
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                     csr_pready,
   output int                       mismatch_count,
   output int                       results_outstanding
);

   localparam int LINE_DEPTH = MAX_WIDTH_DEFAULT;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] gradient;
      logic                  last_of_run;
      logic                  frame_end;
   } gradient_word_type;

   gradient_word_type expected_gradients[$];

   // shadow copies of the csr registers
   logic [WIDTH_BITS-1:0]  image_width;
   logic [HEIGHT_BITS-1:0] image_height;
   logic [THRESH_BITS-1:0] magnitude_threshold;

   // line buffers, raster position and bank select
   logic [PIXEL_BITS-1:0] line_store [0:1][0:LINE_DEPTH-1];
   int unsigned           col_pos;
   int unsigned           row_pos;
   logic                  bank;

   // largest r with r*r <= v, one result bit per pass
   function automatic int unsigned floor_root(input int unsigned v);
      int unsigned r;
      int unsigned trial;
      r = 0;
      for (int b = 8; b >= 0; b--) begin
         trial = r | (32'd1 << b);
         if (trial * trial <= v) r = trial;
      end
      return r;
   endfunction

   // advance the raster state by one accepted word, queue its gradient if any
   task automatic predict_gradient(input logic action, input logic [7:0] pix);
      int unsigned       w, h, c, lft, rgt, up_px, down_px, mag;
      int                dx, dy;
      int                rd_bank, wr_bank;
      logic [7:0]        tap_left, tap_mid, tap_right;
      logic              wrap, produce, frame_done;
      gradient_word_type res;
      w = (image_width == 0) ? 1 : ((image_width > LINE_DEPTH) ? LINE_DEPTH : image_width);
      h = (image_height == 0) ? 1 : image_height;
      // pixels past the frame and ticks inside it are dropped
      if (action == ACTION_PIXEL && row_pos >= h) return;
      if (action == ACTION_DRAIN && row_pos < h) return;
      rd_bank = bank ? 0 : 1;
      wr_bank = bank ? 1 : 0;
      c = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
      lft = (c == 0) ? 0 : c - 1;
      rgt = (c + 1 >= w) ? c : c + 1;
      wrap = (c + 1 >= w);
      tap_left = line_store[rd_bank][lft];
      tap_mid = line_store[rd_bank][c];
      tap_right = line_store[rd_bank][rgt];
      frame_done = 1'b0;
      if (action == ACTION_PIXEL) begin
         // top row of the frame uses itself as upper neighbour
         produce = (row_pos >= 1);
         up_px = (row_pos >= 2) ? line_store[wr_bank][c] : tap_mid;
         down_px = pix;
         line_store[wr_bank][c] = pix;
         if (wrap) begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 32'h1FFF;
            bank = ~bank;
         end else begin
            col_pos = c + 1;
         end
      end else begin
         // bottom row during drain uses itself as lower neighbour
         produce = 1'b1;
         up_px = (h >= 2) ? line_store[wr_bank][c] : tap_mid;
         down_px = tap_mid;
         frame_done = wrap;
         if (wrap) begin
            col_pos = 0;
            row_pos = 0;
         end else begin
            col_pos = c + 1;
         end
      end
      if (!produce) return;
      dx = int'(tap_right) - int'(tap_left);
      dy = int'(down_px) - int'(up_px);
      mag = floor_root(dx * dx + dy * dy) >> 1;
      if (mag < magnitude_threshold) mag = 0;
      res.gradient = mag[7:0];
      res.last_of_run = 1'b1;
      res.frame_end = frame_done;
      expected_gradients.push_back(res);
      results_outstanding = expected_gradients.size();
   endtask

   // watch csr, result and request channels at every rising edge
   always @(posedge clock) begin : watch_channels
      gradient_word_type want;
      if (reset) begin
         image_width = WIDTH_RESET;
         image_height = HEIGHT_RESET;
         magnitude_threshold = THRESH_RESET;
         col_pos = 0;
         row_pos = 0;
         bank = 1'b0;
         expected_gradients.delete();
         results_outstanding = 0;
         mismatch_count = 0;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_IMAGE_WIDTH:         image_width = csr_pwdata[WIDTH_BITS-1:0];
               REG_IMAGE_HEIGHT:        image_height = csr_pwdata[HEIGHT_BITS-1:0];
               REG_MAGNITUDE_THRESHOLD: magnitude_threshold = csr_pwdata[THRESH_BITS-1:0];
               default: ;
            endcase
         end
         // result words against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (expected_gradients.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result word: gradient %0d last %0b frame_end %0b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = expected_gradients.pop_front();
               results_outstanding = expected_gradients.size();
               if (rsp_tdata !== want.gradient || rsp_tlast !== want.last_of_run ||
                   rsp_tuser !== want.frame_end) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("gradient mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                              want.gradient, want.last_of_run, want.frame_end,
                              rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
         // accepted pixel or drain word
         if (req_tvalid && req_tready) predict_gradient(req_tuser, req_tdata);
      end
   end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
   import cdgm_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 32;
   localparam int RANDOM_WORDS   = 400;

   typedef enum int {
      PAT_NOISE,
      PAT_BINARY,
      PAT_RAMP,
      PAT_DIAGONAL
   } pixel_pattern_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata   = '0;   // [7:0] pixel_value
   logic                     req_tuser   = 1'b0; // [0] action
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b1;
   logic [7:0]               rsp_tdata;          // [7:0] gradient_value
   logic                     rsp_tlast;
   logic                     rsp_tuser;          // [0] frame_end
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int mismatch_count;
   int results_outstanding;
   int stall_cycles = 0;
   int words_sent   = 0;
   bit no_gaps      = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   central_difference_gradient_magnitude_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   gradient_stream_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .req_tuser           (req_tuser),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tlast           (rsp_tlast),
      .rsp_tuser           (rsp_tuser),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_pready          (csr_pready),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   // receiver back-pressure
   always @(negedge clock) rsp_tready = no_gaps || ($urandom_range(0, 99) >= 36);

   // watchdog on cycles without any accepted word or register access
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // send one word, called and returning at a falling edge
   task automatic push_word(input logic action, input logic [7:0] pix);
      while (!no_gaps && $urandom_range(0, 99) < 36) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = action;
      req_tdata = pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // setup and access cycle of one register write
   task automatic write_register(input cdgm_reg_index_type idx, input logic [31:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic wait_results_drained();
      req_tvalid = 1'b0;
      while (results_outstanding != 0) @(negedge clock);
   endtask

   // one frame: registers, pixels in raster order, then drain ticks
   task automatic run_frame(input int wd, input int ht, input int thr,
                            input pixel_pattern_type pattern, input bit noisy,
                            input bit hold_midway);
      int         eff_w, eff_h, total, pause_at, k, col, row;
      logic [7:0] pix;
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_register(REG_IMAGE_WIDTH, 32'(wd));
      write_register(REG_IMAGE_HEIGHT, 32'(ht));
      write_register(REG_MAGNITUDE_THRESHOLD, 32'(thr));
      eff_w = (wd == 0) ? 1 : ((wd > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : wd);
      eff_h = (ht == 0) ? 1 : ht;
      total = eff_w * eff_h;
      pause_at = hold_midway ? $urandom_range(0, total - 1) : -1;
      for (k = 0; k < total; k++) begin
         col = k % eff_w;
         row = k / eff_w;
         if (k == pause_at) wait_results_drained();
         // drain tick while the frame is still coming in is dropped
         if (noisy && (k == total / 2 || $urandom_range(0, 39) == 0))
            push_word(ACTION_DRAIN, 8'($urandom));
         case (pattern)
            PAT_NOISE:    pix = 8'($urandom_range(0, 255));
            PAT_BINARY:   pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PAT_RAMP:     pix = 8'(col * 3 + row * 5 + $urandom_range(0, 3));
            default:      pix = (row + col >= eff_w) ? 8'hFF : 8'h00;
         endcase
         push_word(ACTION_PIXEL, pix);
         words_sent++;
      end
      for (k = 0; k < eff_w; k++) begin
         // pixel during the drain phase is dropped
         if (noisy && (k == 0 || $urandom_range(0, 19) == 0))
            push_word(ACTION_PIXEL, 8'($urandom));
         push_word(ACTION_DRAIN, 8'($urandom));
         words_sent++;
      end
      // stray tick once the frame is closed
      if (noisy) push_word(ACTION_DRAIN, 8'($urandom));
   endtask

   initial begin
      int frame_no;
      int wd, ht, thr;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: max magnitude with edge replication, then a single-row frame
      run_frame(3, 3, 0, PAT_DIAGONAL, 1'b1, 1'b1);
      run_frame(4, 1, 180, PAT_BINARY, 1'b0, 1'b0);

      // random small frames, one stretch without any gaps
      words_sent = 0;
      frame_no = 0;
      while (words_sent < RANDOM_WORDS) begin
         no_gaps = (frame_no >= 4 && frame_no < 8);
         case ($urandom_range(0, 19))
            0:       wd = $urandom_range(9, 48);
            1:       wd = 0;
            default: wd = $urandom_range(1, 8);
         endcase
         ht = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
         case ($urandom_range(0, 7))
            0:       thr = 255;
            1, 2:    thr = $urandom_range(1, 40);
            3:       thr = $urandom_range(0, 255);
            default: thr = 0;
         endcase
         run_frame(wd, ht, thr, pixel_pattern_type'($urandom_range(0, 3)),
                   $urandom_range(0, 2) == 0, $urandom_range(0, 4) == 0);
         frame_no++;
      end

      // register extremes: one-pixel rows, a wider ramp without gaps, zero sizes
      no_gaps = 1'b0;
      run_frame(1, 24, $urandom_range(0, 20), PAT_NOISE, 1'b0, 1'b1);
      no_gaps = 1'b1;
      run_frame(16, 2, 0, PAT_RAMP, 1'b0, 1'b0);
      no_gaps = 1'b0;
      run_frame(0, 0, 0, PAT_BINARY, 1'b1, 1'b0);

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
